FILE: src/srm_pkg.sv
package srm_pkg;

  localparam int unsigned     TASKS_DEF      = 256;
  localparam longint unsigned MAX_RANGES_DEF = 64'd1048576;

  localparam int unsigned TASK_W  = 8;
  localparam int unsigned TAG_W   = 16;
  localparam int unsigned COORD_W = 64;
  localparam int unsigned MAP_W   = 16;
  localparam int unsigned IDX_W   = 20;

  // largest value the index field can carry
  localparam logic [IDX_W-1:0] IDX_MAX = '1;
  localparam logic [MAP_W-1:0] MAP_MAX = '1;

  // output queue depth; must hold two results beyond one in flight
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [TASK_W-1:0]         task_id;
    logic [TAG_W-1:0]          range_tag;
    logic signed [COORD_W-1:0] range_start;
    logic signed [COORD_W-1:0] range_end;
    logic                      final_range;
  } in_word_t;

  typedef struct packed {
    logic [TASK_W-1:0]         out_task;
    logic [TAG_W-1:0]          out_tag;
    logic signed [COORD_W-1:0] out_start;
    logic signed [COORD_W-1:0] out_end;
    logic [MAP_W-1:0]          map_number;
    logic [IDX_W-1:0]          out_index;
    logic                      last_out;
  } out_word_t;

  // up to two results from one item; a lone result always sits in slot 0
  typedef struct packed {
    logic      v0;
    logic      v1;
    out_word_t w0;
    out_word_t w1;
  } push_t;

endpackage

FILE: src/srm_core.sv
module srm_core #(
  parameter int unsigned     TASKS      = srm_pkg::TASKS_DEF,
  parameter longint unsigned MAX_RANGES = srm_pkg::MAX_RANGES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic             cfg_data,
  input  logic             go,
  input  srm_pkg::in_word_t item,
  output srm_pkg::push_t   push
);

  localparam logic [16:0] TaskLimit = 17'(TASKS);
  localparam logic [srm_pkg::IDX_W-1:0] IdxCap =
    ((MAX_RANGES - 64'd1) < 64'(srm_pkg::IDX_MAX)) ?
    srm_pkg::IDX_W'(MAX_RANGES - 64'd1) : srm_pkg::IDX_MAX;

  typedef struct packed {
    logic                         emitted_any;
    logic [srm_pkg::TASK_W-1:0]   prev_task;
    logic [srm_pkg::TAG_W-1:0]    prev_tag;
    logic [srm_pkg::MAP_W-1:0]    map_ctr;
    logic [srm_pkg::IDX_W-1:0]    emit_ctr;
  } emit_state_t;

  function automatic emit_state_t emit_update(emit_state_t st,
                                              logic [srm_pkg::TASK_W-1:0] t,
                                              logic [srm_pkg::TAG_W-1:0] g);
    emit_state_t ns;
    ns = st;
    if (!st.emitted_any || t != st.prev_task) begin
      ns.map_ctr = '0;
    end else if (g == '0 || g != st.prev_tag) begin
      if (st.map_ctr != srm_pkg::MAP_MAX) ns.map_ctr = st.map_ctr + 1'b1;
    end
    ns.emitted_any = 1'b1;
    ns.prev_task   = t;
    ns.prev_tag    = g;
    if (st.emit_ctr < IdxCap) ns.emit_ctr = st.emit_ctr + 1'b1;
    return ns;
  endfunction

  logic        merge_en;
  logic        pend_valid;
  logic [srm_pkg::TASK_W-1:0]         pend_task;
  logic [srm_pkg::TAG_W-1:0]          pend_tag;
  logic signed [srm_pkg::COORD_W-1:0] pend_start;
  logic signed [srm_pkg::COORD_W-1:0] pend_end;
  emit_state_t est;

  logic        in_range, do_merge, emit_a, emit_b;
  logic        pend_valid_next;
  logic [srm_pkg::TASK_W-1:0]         pend_task_next;
  logic [srm_pkg::TAG_W-1:0]          pend_tag_next;
  logic signed [srm_pkg::COORD_W-1:0] pend_start_next;
  logic signed [srm_pkg::COORD_W-1:0] pend_end_next;
  emit_state_t st_a, st_b, est_next;
  srm_pkg::out_word_t word_a, word_b;

  always_comb begin
    in_range = {9'd0, item.task_id} < TaskLimit;
    do_merge = merge_en && pend_valid && item.task_id == pend_task &&
               item.range_tag == pend_tag && item.range_start <= pend_end;
    emit_a   = in_range && !do_merge && pend_valid;

    // displaced pending range
    st_a = emit_a ? emit_update(est, pend_task, pend_tag) : est;
    word_a.out_task   = pend_task;
    word_a.out_tag    = pend_tag;
    word_a.out_start  = pend_start;
    word_a.out_end    = pend_end;
    word_a.map_number = st_a.map_ctr;
    word_a.out_index  = est.emit_ctr;
    word_a.last_out   = 1'b0;

    // pending after the item is folded in
    pend_valid_next = pend_valid | in_range;
    pend_task_next  = pend_task;
    pend_tag_next   = pend_tag;
    pend_start_next = pend_start;
    pend_end_next   = pend_end;
    if (in_range) begin
      if (do_merge) begin
        if (item.range_end > pend_end) pend_end_next = item.range_end;
      end else begin
        pend_task_next  = item.task_id;
        pend_tag_next   = item.range_tag;
        pend_start_next = item.range_start;
        pend_end_next   = item.range_end;
      end
    end

    // flush on final
    emit_b = item.final_range && pend_valid_next;
    st_b = emit_b ? emit_update(st_a, pend_task_next, pend_tag_next) : st_a;
    word_b.out_task   = pend_task_next;
    word_b.out_tag    = pend_tag_next;
    word_b.out_start  = pend_start_next;
    word_b.out_end    = pend_end_next;
    word_b.map_number = st_b.map_ctr;
    word_b.out_index  = st_a.emit_ctr;
    word_b.last_out   = 1'b1;

    est_next = st_b;
    if (item.final_range) begin
      pend_valid_next      = 1'b0;
      est_next.emitted_any = 1'b0;
      est_next.map_ctr     = '0;
      est_next.emit_ctr    = '0;
    end

    push.v0 = go && (emit_a || emit_b);
    push.v1 = go && emit_a && emit_b;
    push.w0 = emit_a ? word_a : word_b;
    push.w1 = word_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      merge_en   <= 1'b1;
      pend_valid <= 1'b0;
      est        <= '0;
    end else begin
      if (cfg_write) merge_en <= cfg_data;
      if (go) begin
        pend_valid <= pend_valid_next;
        est        <= est_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      pend_task  <= pend_task_next;
      pend_tag   <= pend_tag_next;
      pend_start <= pend_start_next;
      pend_end   <= pend_end_next;
    end
  end

endmodule

FILE: src/srm_queue.sv
module srm_queue (
  input  logic               clk,
  input  logic               rst,
  input  srm_pkg::push_t     push,
  output logic               room,
  output logic               out_valid,
  input  logic               out_stall,
  output srm_pkg::out_word_t out_data
);

  localparam int unsigned Depth = srm_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  srm_pkg::out_word_t mem [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count, count_next;
  logic            pop;
  logic [1:0]      push_n;

  always_comb begin
    pop        = out_valid && !out_stall;
    push_n     = 2'(push.v0) + 2'(push.v1);
    count_next = count + CntW'(push_n) - CntW'(pop);
    out_valid  = count != '0;
    room       = count <= CntW'(Depth - 2);
    out_data   = mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(push_n);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) mem[wr_ptr] <= push.w0;
    if (push.v1) mem[wr_ptr + 1'b1] <= push.w1;
  end

endmodule

FILE: src/sorted_range_merge_and_map_number_top.sv
// Path: an accepted word waits in the input register, then the merge/emit
//   logic writes its results into the output queue, which presents them.
// Throughput: one input word per cycle while the queue has room; a word
//   flushing two ranges queues two, drained one per cycle unless stalled.
// Reset (rst, synchronous): nothing pending, queue empty, counters zero,
//   merge_enable set to 1.
module sorted_range_merge_and_map_number_top #(
  parameter int unsigned     TASKS      = srm_pkg::TASKS_DEF,
  parameter longint unsigned MAX_RANGES = srm_pkg::MAX_RANGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  srm_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output srm_pkg::out_word_t out_data
);

  // Input register: holds one word until the queue has room for the two
  // results it may produce.
  logic              in_q_valid;
  srm_pkg::in_word_t in_q;
  logic              room;
  logic              fire;
  logic              accept;
  srm_pkg::push_t    push;

  // The word is processed when the queue can take two results; the input
  // register then frees up in the same cycle.
  assign fire     = in_q_valid && room;
  assign in_stall = in_q_valid && !room;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (accept) begin
      in_q_valid <= 1'b1;
    end else if (fire) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) in_q <= in_data;
  end

  // Pending range, merge test, map numbering and index counting.
  srm_core #(
    .TASKS      (TASKS),
    .MAX_RANGES (MAX_RANGES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .go        (fire),
    .item      (in_q),
    .push      (push)
  );

  // Output queue: takes up to two words a cycle, gives one unless stalled.
  srm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // the input side only backs up behind a held word
  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_q_valid)
    else $error("input stalled with empty input register");

  // a second result from one word is always the final flush
  a_second_is_last: assert property (@(posedge clk) disable iff (rst)
    push.v1 |-> (push.v0 && push.w1.last_out && !push.w0.last_out))
    else $error("second result is not the final flush");

  // after a push the output is valid on the next cycle
  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    push.v0 |=> out_valid)
    else $error("pushed word not presented");
`endif

endmodule
